### hw/rtl/ttce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and constants for the text terminal character engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

    // Character codes
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Item commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [5:0] ROWS_RESET = 6'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    // Input item
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       bell;
        logic [4:0] changed_row;
        logic [6:0] read_char;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the input item
        logic look;     // look up the physical row
        logic exec;     // perform the item's main action
        logic wipe;     // clear one cell of the target row
        logic clear;    // clear one cell of the store after reset
        logic emit;     // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_lf;
        logic wipe_last;
        logic clear_last;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/ttce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_ctrl
// Sequencer for the terminal engine: reset clearing pass, item lookup,
// action, row wipe and result hand-off.
// ----------------------------------------------------------------------------
module ttce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output ttce_pkg::t_dp_cmd o_cmd,
    input  ttce_pkg::t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_EXEC  = 6'b001000,
        S_WIPE  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_lf ? S_WIPE : S_EMIT;
            end
            S_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_sts.wipe_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/ttce_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_dpath
// Datapath: configuration, cursor, logical-to-physical row map, cell store
// and result register. Scrolling rotates the row map; only the freed row
// is wiped.
// ----------------------------------------------------------------------------
module ttce_dpath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ttce_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output ttce_pkg::t_out_item                 o_out_data,
    input  ttce_pkg::t_dp_cmd                   i_cmd,
    output ttce_pkg::t_dp_sts                   o_sts
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    // Registers
    logic [5:0]          r_rows_cfg;
    logic [7:0]          r_cols_cfg;
    logic [RW-1:0]       r_cur_row;
    logic [CW-1:0]       r_cur_col;
    ttce_pkg::t_in_item  r_item;
    logic [RW-1:0]       r_map [MAX_ROWS];
    logic [RW-1:0]       n_map [MAX_ROWS];
    logic [RW-1:0]       r_phys;
    logic [CW-1:0]       r_wipe_cnt;
    logic [AW-1:0]       r_clr_cnt;
    logic [6:0]          r_mem [DEPTH];
    logic [6:0]          r_rd_q;
    logic                r_out_vld;
    ttce_pkg::t_out_item r_out;

    // Effective region size, clamped into 1..MAX
    logic [15:0] rows_raw, cols_raw, rows_eff, cols_eff;
    assign rows_raw = 16'(r_rows_cfg);
    assign cols_raw = 16'(r_cols_cfg);
    assign rows_eff = (rows_raw == 16'd0) ? 16'd1 :
                      (rows_raw > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : rows_raw;
    assign cols_eff = (cols_raw == 16'd0) ? 16'd1 :
                      (cols_raw > 16'(MAX_COLS)) ? 16'(MAX_COLS) : cols_raw;

    // Cursor clamped into the region
    logic [15:0]   row16, col16;
    logic [RW-1:0] c_row, row_next;
    logic [CW-1:0] c_col;
    logic          at_last;
    assign row16 = 16'(r_cur_row);
    assign col16 = 16'(r_cur_col);
    assign c_row = (row16 >= rows_eff) ? RW'(rows_eff - 16'd1) : r_cur_row;
    assign c_col = (col16 >= cols_eff) ? CW'(cols_eff - 16'd1) : r_cur_col;
    assign at_last  = (16'(c_row) == (rows_eff - 16'd1));
    assign row_next = c_row + RW'(1);

    // Item decode
    logic is_read, is_print, is_lf, is_cr, is_bel, rd_oob, col_adv;
    logic [15:0] rr16, rc16;
    assign is_read  = (r_item.cmd == ttce_pkg::CMD_READ);
    assign is_print = !is_read && (r_item.ch >= ttce_pkg::CH_SPACE)
                      && (r_item.ch <= ttce_pkg::CH_TILDE);
    assign is_lf    = !is_read && (r_item.ch == ttce_pkg::CH_LF);
    assign is_cr    = !is_read && (r_item.ch == ttce_pkg::CH_CR);
    assign is_bel   = !is_read && (r_item.ch == ttce_pkg::CH_BEL);
    assign rr16     = 16'(r_item.read_row);
    assign rc16     = 16'(r_item.read_col);
    assign rd_oob   = (rr16 >= 16'(MAX_ROWS)) || (rc16 >= 16'(MAX_COLS));
    assign col_adv  = ((16'(c_col) + 16'd1) < cols_eff);

    // Logical row whose physical row this item touches
    logic [RW-1:0] look_idx;
    assign look_idx = is_read ? rr16[RW-1:0] :
                      is_lf   ? (at_last ? '0 : row_next) : c_row;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= ttce_pkg::ROWS_RESET;
            r_cols_cfg <= ttce_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttce_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data[5:0];
                ttce_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor: re-clamped every cycle, moved by the item action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else if (i_cmd.exec) begin
            r_cur_row <= (is_lf && !at_last) ? row_next : c_row;
            if (is_print && col_adv) begin
                r_cur_col <= c_col + CW'(1);
            end else if (is_cr) begin
                r_cur_col <= '0;
            end else begin
                r_cur_col <= c_col;
            end
        end else begin
            r_cur_row <= c_row;
            r_cur_col <= c_col;
        end
    end

    // Item latch and physical row lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.look) begin
            r_phys <= r_map[look_idx];
        end
    end

    // Scroll: rows above the bottom take the next row, bottom takes row 0
    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_rot
        logic [RW-1:0] map_up;
        if (g < MAX_ROWS - 1) begin : g_up
            assign map_up = r_map[g+1];
        end else begin : g_top
            assign map_up = r_map[g];
        end
        assign n_map[g] = (16'(g) < (rows_eff - 16'd1)) ? map_up :
                          (16'(g) == (rows_eff - 16'd1)) ? r_map[0] : r_map[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                r_map[i] <= RW'(i);
            end
        end else if (i_cmd.exec && is_lf && at_last) begin
            r_map <= n_map;
        end
    end

    // Sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_wipe_cnt <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.exec) begin
                r_wipe_cnt <= '0;
            end else if (i_cmd.wipe) begin
                r_wipe_cnt <= r_wipe_cnt + CW'(1);
            end
        end
    end

    // Cell store port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [6:0]    mem_wdata;
    assign mem_we    = i_cmd.clear || i_cmd.wipe || (i_cmd.exec && is_print);
    assign mem_re    = i_cmd.exec && is_read;
    assign mem_wdata = (i_cmd.exec && is_print) ? r_item.ch[6:0] : 7'd0;
    assign mem_addr  = i_cmd.clear ? r_clr_cnt :
                       i_cmd.wipe  ? {r_phys, r_wipe_cnt} :
                       is_read     ? {r_phys, rc16[CW-1:0]} : {r_phys, c_col};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q <= r_mem[mem_addr];
        end
    end

    // Result register
    logic [15:0] out_row16, out_col16;
    assign out_row16 = 16'(r_cur_row);
    assign out_col16 = 16'(r_cur_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.cursor_row  <= out_row16[4:0];
            r_out.cursor_col  <= out_col16[6:0];
            r_out.bell        <= is_bel;
            r_out.changed_row <= is_read ? 5'd0 : out_row16[4:0];
            r_out.read_char   <= (is_read && !rd_oob) ? r_rd_q : 7'd0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Status
    assign o_sts.is_lf      = is_lf;
    assign o_sts.wipe_last  = (r_wipe_cnt == CW'(MAX_COLS - 1));
    assign o_sts.clear_last = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

endmodule

### hw/rtl/text_terminal_char_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_engine
// Dumb text terminal: cell store, cursor, line feed with scroll, bell flag,
// single-cell read-back.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------
//  input     | i_in_valid / o_in_ready  | i_in_data  (cmd, ch, read row/col)
//  result    | o_out_valid / i_out_ready| o_out_data (cursor, bell, row, char)
//  config    | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  Put and read items pass through the lookup, action and result states;
//  a line feed also passes the wipe state, which clears the cursor's new
//  row one cell per cycle through the single store port. Scrolling itself
//  is a row map rotation.
//  After reset a clearing pass over all MAX_ROWS * 2**clog2(MAX_COLS)
//  cells (4096 by default) runs before the first item is taken.
//  A stalled result holds in the output register; the next item may be
//  taken meanwhile and completes once the register frees.
// ----------------------------------------------------------------------------
module text_terminal_char_engine #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ttce_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ttce_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttce_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ttce_pkg::t_dp_cmd dp_cmd;
    ttce_pkg::t_dp_sts dp_sts;

    // Sequencer
    ttce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    // Datapath
    ttce_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule
